@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lfu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned CAP_W = 5;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT,
    ST_INSERT,
    ST_UPDATE,
    ST_RESP
  } lfu_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;
    logic scan_start;
    logic scan_step;
    logic do_bump;
    logic do_evict;
    logic do_insert;
    logic fin_miss;
  } lfu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic is_put;
    logic need_evict;
    logic can_insert;
  } lfu_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/lfu_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface lfu_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] req_key;
  logic [31:0] req_value;
  modport source (output valid, req_type, req_key, req_value, input ready);
  modport sink (input valid, req_type, req_key, req_value, output ready);
endinterface

interface lfu_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] read_value;
  logic        stored;
  logic        evicted;
  logic [31:0] evicted_key;
  modport source (output valid, hit, read_value, stored, evicted, evicted_key,
                  input ready);
  modport sink (input valid, hit, read_value, stored, evicted, evicted_key,
                output ready);
endinterface
`default_nettype wire

@@ rtl/core/lfu_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lfu_ctrl import lfu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire lfu_stat_t  stat,
  output lfu_cmd_t        cmd,
  output lfu_state_t      state_o
);

  lfu_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign state_o = state;

  // Sequencing: scan, then evict/insert or bump (a get miss skips both), then respond
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req   = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stat.scan_done) begin
          cmd.scan_step = 1'b1;
        end else if (stat.found) begin
          state_next = ST_UPDATE;
        end else if (!stat.is_put) begin
          cmd.fin_miss = 1'b1;
          state_next   = ST_RESP;
        end else if (stat.need_evict) begin
          state_next = ST_EVICT;
        end else begin
          state_next = ST_INSERT;
        end
      end
      ST_EVICT: begin
        cmd.do_evict = 1'b1;
        state_next   = ST_INSERT;
      end
      ST_INSERT: begin
        // no room left: result keeps stored low
        if (stat.can_insert) cmd.do_insert = 1'b1;
        state_next = ST_RESP;
      end
      ST_UPDATE: begin
        cmd.do_bump = 1'b1;
        state_next  = ST_RESP;
      end
      ST_RESP: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/lfu_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lfu_dp import lfu_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lfu_cmd_t         cmd,
  output lfu_stat_t             stat,
  input  wire logic             cap_we,
  input  wire logic [CAP_W-1:0] cap_wdata,
  input  wire logic             req_type,
  input  wire logic [31:0]      req_key,
  input  wire logic [31:0]      req_value,
  output logic                  hit,
  output logic [31:0]           read_value,
  output logic                  stored,
  output logic                  evicted,
  output logic [31:0]           evicted_key,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] occ_o
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned RW = IW;
  localparam int unsigned OW = $clog2(TABLE_DEPTH + 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [OW:0] DEPTH_V = (OW+1)'(TABLE_DEPTH);

  // Per-entry registers; each bit and rank is updated in parallel
  logic [TABLE_DEPTH-1:0] vld;
  logic [KEY_W-1:0]       ekey [TABLE_DEPTH];
  logic [31:0]            edat [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] ecnt [TABLE_DEPTH];
  logic [RW-1:0]          erank[TABLE_DEPTH];
  logic [OW-1:0]          occ;
  logic [CAP_W-1:0]       cap;

  // Request and scan registers
  logic             r_put;
  logic [31:0]      r_key, r_val;
  logic [OW-1:0]    idx;
  logic             done, found, fslot_ok, vic_ok;
  logic [IW-1:0]    fidx, fslot, vidx;
  logic [COUNT_WIDTH-1:0] vcnt;
  logic [RW-1:0]    vrank;

  logic [IW-1:0]    ci;
  logic [OW:0]      cap_eff;

  assign ci      = idx[IW-1:0];
  assign cap_eff = ((OW+1)'(cap) > DEPTH_V) ? DEPTH_V : (OW+1)'(cap);
  assign occ_o   = occ;

  assign stat.scan_done  = done;
  assign stat.found      = found;
  assign stat.is_put     = r_put;
  assign stat.need_evict = ((OW+1)'(occ) + 1'b1 > cap_eff) && (occ != '0) && vic_ok;
  assign stat.can_insert = ((OW+1)'(occ) < cap_eff) && fslot_ok;

  always_ff @(posedge clk) begin
    if (rst) cap <= CAP_W'(16);
    else if (cap_we) cap <= cap_wdata;
  end

  // Scan one entry a cycle: key match, first free slot, victim
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      r_put <= req_type;
      r_key <= req_key;
      r_val <= req_value;
    end
    if (cmd.scan_start) begin
      idx <= '0; done <= 1'b0; found <= 1'b0;
      fslot_ok <= 1'b0; vic_ok <= 1'b0;
    end else if (cmd.scan_step) begin
      if (vld[ci]) begin
        if (ekey[ci] == r_key && !found) begin
          found <= 1'b1; fidx <= ci;
        end
        if (!vic_ok || ecnt[ci] < vcnt || (ecnt[ci] == vcnt && erank[ci] > vrank)) begin
          vic_ok <= 1'b1; vidx <= ci; vcnt <= ecnt[ci]; vrank <= erank[ci];
        end
      end else if (!fslot_ok) begin
        fslot_ok <= 1'b1; fslot <= ci;
      end
      if (idx == OW'(TABLE_DEPTH - 1)) done <= 1'b1;
      else idx <= idx + 1'b1;
    end else if (cmd.do_evict) begin
      // freed victim slot becomes the free slot if there is none or it is lower
      if (!fslot_ok || vidx < fslot) begin
        fslot_ok <= 1'b1; fslot <= vidx;
      end
    end
  end

  // Table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      occ <= '0;
    end else if (cmd.do_bump) begin
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (vld[i] && erank[i] < erank[fidx]) erank[i] <= erank[i] + 1'b1;
      erank[fidx] <= '0;
      if (ecnt[fidx] != CNT_MAX) ecnt[fidx] <= ecnt[fidx] + 1'b1;
      if (r_put) edat[fidx] <= r_val;
    end else if (cmd.do_evict) begin
      vld[vidx] <= 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (vld[i] && erank[i] > vrank) erank[i] <= erank[i] - 1'b1;
      occ <= occ - 1'b1;
    end else if (cmd.do_insert) begin
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (vld[i]) erank[i] <= erank[i] + 1'b1;
      vld[fslot]   <= 1'b1;
      ekey[fslot]  <= r_key;
      edat[fslot]  <= r_val;
      ecnt[fslot]  <= COUNT_WIDTH'(1);
      erank[fslot] <= '0;
      occ <= occ + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      hit <= 1'b0; read_value <= '0; stored <= 1'b0;
      evicted <= 1'b0; evicted_key <= '0;
    end else if (cmd.do_bump) begin
      hit <= 1'b1;
      stored <= r_put;
      read_value <= r_put ? 32'd0 : edat[fidx];
    end else if (cmd.fin_miss) begin
      read_value <= '1;
    end else if (cmd.do_evict) begin
      evicted <= 1'b1;
      evicted_key <= ekey[vidx];
    end else if (cmd.do_insert) begin
      stored <= 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lfu_cache_lru_tiebreak.sv @@
// Flow: after accept the datapath scans one entry per cycle. A get miss then
// goes to the result; a hit first takes an update step, a put miss an insert
// step, and a put miss at capacity an evict step followed by an insert step.
// A new request is accepted only once the result has been taken.
// Reset (rst, synchronous): table empty, capacity 16, controller idle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lfu_cache_lru_tiebreak import lfu_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  lfu_req_if.sink               req,
  lfu_rsp_if.source             rsp,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata
);

  lfu_cmd_t   cmd;
  lfu_stat_t  stat;
  lfu_state_t state;
  logic [$clog2(TABLE_DEPTH+1)-1:0] occ;

  lfu_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (req.valid), .in_ready (req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .stat, .cmd, .state_o(state)
  );

  lfu_dp #(.TABLE_DEPTH(TABLE_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk, .rst, .cmd, .stat,
    .cap_we(cfg_we), .cap_wdata(cfg_wdata),
    .req_type(req.req_type), .req_key(req.req_key), .req_value(req.req_value),
    .hit(rsp.hit), .read_value(rsp.read_value), .stored(rsp.stored),
    .evicted(rsp.evicted), .evicted_key(rsp.evicted_key),
    .occ_o(occ)
  );

  `ASSERT_IMPL(a_occ_bound, 1'b1, occ <= TABLE_DEPTH, "occupancy above depth")
  `ASSERT_IMPL(a_ready_idle, req.ready, !rsp.valid, "ready while result pending")
  `ASSERT_NEXT(a_evict_then_insert, state == ST_EVICT, state == ST_INSERT,
               "eviction not followed by insert step")
  `ASSERT_IMPL(a_get_no_store, rsp.valid && !rsp.hit && rsp.read_value == 32'hFFFFFFFF,
               !rsp.stored && !rsp.evicted, "get miss reports store")

endmodule
`default_nettype wire
